FILE: design/sixiir_pkg.sv
// Shared types and constants for the six-axis IIR low-pass decimator.
// No dependencies; imported by the core.
package sixiir_pkg;

	localparam int AXES       = 6;   // channels per sample beat
	localparam int COEF_W     = 16;  // Q0.16 feedback coefficient
	localparam int COEF_SHIFT = 16;
	localparam int DEC_REG_W  = 9;   // decimation register width
	localparam int APB_DW     = 32;
	localparam int APB_AW     = 3;

	// register select bit (paddr[2])
	localparam logic REG_COEF_A     = 1'b0;
	localparam logic REG_DECIMATION = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_ACC,
		ST_DIV,
		ST_ADV,
		ST_DONE
	} sixiir_state_t;

endpackage

FILE: design/six_axis_iir_lowpass_decimator_core.sv
// Six-axis first-order IIR low-pass with a decimating window mean.
// Depends on sixiir_pkg (constants, sequencer state type).
//
// Usage:
//  - Input channel (in_valid / in_stall): one beat carries one six-axis
//    force/torque sample. in_stall is low only while the sequencer is idle.
//  - Output channel (out_valid / out_stall): one beat per completed window,
//    carrying the truncated mean of the filtered samples of that window.
//  - APB port: register 0 (0x0) coef_a, Q0.16 feedback coefficient;
//    register 1 (0x4) decimation, samples per window (0 acts as 1, values
//    above MAX_DECIMATION act as MAX_DECIMATION). Write only while idle.
//  - Per-axis state (previous input, previous output, window sum) lives in
//    one synchronous RAM of AXES entries with a registered read. Axes run
//    one at a time (read, multiply, write back), so accesses never overlap.
//  - Sequence: each axis passes through read, multiply, accumulate and
//    advance. A window-closing beat adds a restoring divider of SUM_W steps
//    per axis (24 at defaults); the result is loaded into the output
//    register from the final state once the last axis is divided.
//  - Reset: coef_a = 0, decimation = 1, window position 1; RAM entries read
//    as zero until their first write-back (per-entry valid flops).
//  - A result waiting under out_stall does not block new samples; only a
//    window-closing beat waits in its final state for the output register.
module six_axis_iir_lowpass_decimator_core
	import sixiir_pkg::*;
#(
	parameter int SAMPLE_BITS    = 16,
	parameter int MAX_DECIMATION = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// sample channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] force_x,
	input  logic signed [SAMPLE_BITS-1:0] force_y,
	input  logic signed [SAMPLE_BITS-1:0] force_z,
	input  logic signed [SAMPLE_BITS-1:0] torque_x,
	input  logic signed [SAMPLE_BITS-1:0] torque_y,
	input  logic signed [SAMPLE_BITS-1:0] torque_z,
	// mean channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] mean_force_x,
	output logic signed [SAMPLE_BITS-1:0] mean_force_y,
	output logic signed [SAMPLE_BITS-1:0] mean_force_z,
	output logic signed [SAMPLE_BITS-1:0] mean_torque_x,
	output logic signed [SAMPLE_BITS-1:0] mean_torque_y,
	output logic signed [SAMPLE_BITS-1:0] mean_torque_z,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [APB_AW-1:0]             paddr,
	input  logic [APB_DW-1:0]             pwdata,
	output logic [APB_DW-1:0]             prdata,
	output logic                          pready
);

	localparam int S      = SAMPLE_BITS;
	localparam int CNT_W  = $clog2(MAX_DECIMATION + 1);
	localparam int CW     = (CNT_W > DEC_REG_W) ? CNT_W : DEC_REG_W;
	localparam int SUM_W  = S + $clog2(MAX_DECIMATION);
	localparam int PW     = S + COEF_W + 2;          // filter product width
	localparam int ENT_W  = 2 * S + SUM_W;           // {x_prev, y_prev, sum}
	localparam int AX_W   = (AXES > 1) ? $clog2(AXES) : 1;
	localparam int STP_W  = $clog2(SUM_W);

	localparam logic [AX_W-1:0]  AX_LAST  = AX_W'(AXES - 1);
	localparam logic [STP_W-1:0] STP_LAST = STP_W'(SUM_W - 1);
	localparam logic [CW-1:0]    DEC_MAX  = CW'(MAX_DECIMATION);
	localparam logic [SUM_W-1:0] POS_LIM  = {{(SUM_W - S + 1){1'b0}}, {(S - 1){1'b1}}};
	localparam logic [SUM_W-1:0] NEG_LIM  = POS_LIM + SUM_W'(1);

	// ---------------------------------------------------------------
	// Configuration registers (APB, zero wait states)
	// ---------------------------------------------------------------
	logic [COEF_W-1:0]    coef_a_q;
	logic [DEC_REG_W-1:0] decimation_q;
	logic                 cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q     <= '0;
			decimation_q <= DEC_REG_W'(1);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_COEF_A:     coef_a_q     <= pwdata[COEF_W-1:0];
				REG_DECIMATION: decimation_q <= pwdata[DEC_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_COEF_A:     prdata = {{(APB_DW - COEF_W){1'b0}}, coef_a_q};
			REG_DECIMATION: prdata = {{(APB_DW - DEC_REG_W){1'b0}}, decimation_q};
			default:        prdata = '0;
		endcase
	end

	// effective window length: zero acts as one, clip at the maximum
	logic [CW-1:0]    dec_wide;
	logic [CNT_W-1:0] dec_eff;

	always_comb begin
		dec_wide = CW'(decimation_q);
		if (dec_wide == '0)
			dec_eff = CNT_W'(1);
		else if (dec_wide > DEC_MAX)
			dec_eff = DEC_MAX[CNT_W-1:0];
		else
			dec_eff = dec_wide[CNT_W-1:0];
	end

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	sixiir_state_t state_q, state_d;

	logic              in_acc;
	logic              out_free;
	logic              rd_en, wr_en, div_load, div_step, res_load;
	logic [AX_W-1:0]   axis_q;
	logic [STP_W-1:0]  step_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              emit_q;

	assign in_acc   = in_valid & ~in_stall;
	assign out_free = ~out_valid | ~out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_READ;
			ST_READ: state_d = ST_MUL;
			ST_MUL:  state_d = ST_ACC;
			ST_ACC:  state_d = emit_q ? ST_DIV : ST_ADV;
			ST_DIV:  if (step_q == STP_LAST) state_d = ST_ADV;
			ST_ADV: begin
				if (axis_q != AX_LAST)
					state_d = ST_READ;
				else
					state_d = emit_q ? ST_DONE : ST_IDLE;
			end
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		div_load = 1'b0;
		div_step = 1'b0;
		res_load = 1'b0;
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_READ: rd_en    = 1'b1;
			ST_ACC: begin
				wr_en    = 1'b1;
				div_load = 1'b1;
			end
			ST_DIV:  div_step = 1'b1;
			ST_DONE: res_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= '0;
			cnt_q   <= CNT_W'(1);
			emit_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				axis_q <= '0;
				// window closes when the position reaches the length
				if (cnt_q >= dec_eff) begin
					emit_q <= 1'b1;
					cnt_q  <= CNT_W'(1);
				end else begin
					emit_q <= 1'b0;
					cnt_q  <= cnt_q + CNT_W'(1);
				end
			end else if (state_q == ST_ADV && axis_q != AX_LAST) begin
				axis_q <= axis_q + AX_W'(1);
			end
		end
	end

	// sample beat captured whole; axes are consumed one per pass
	logic [S-1:0] in_q [AXES];

	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_q[0] <= force_x;
			in_q[1] <= force_y;
			in_q[2] <= force_z;
			in_q[3] <= torque_x;
			in_q[4] <= torque_y;
			in_q[5] <= torque_z;
		end
	end

	// ---------------------------------------------------------------
	// Per-axis state RAM, registered read
	// ---------------------------------------------------------------
	logic [ENT_W-1:0] mem [AXES];
	logic [AXES-1:0]  vld_q;
	logic [ENT_W-1:0] rd_s1;
	logic             rd_vld_s1;
	logic [ENT_W-1:0] wr_data;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[axis_q] <= wr_data;
		if (rd_en)
			rd_s1 <= mem[axis_q];
	end

	// entries read as zero until first written back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[axis_q] <= 1'b1;
			if (rd_en)
				rd_vld_s1 <= vld_q[axis_q];
		end
	end

	logic [S-1:0]     x_prev, y_prev;
	logic [SUM_W-1:0] sum_prev;

	assign x_prev   = rd_vld_s1 ? rd_s1[ENT_W-1 -: S]       : '0;
	assign y_prev   = rd_vld_s1 ? rd_s1[SUM_W + S - 1 -: S] : '0;
	assign sum_prev = rd_vld_s1 ? rd_s1[SUM_W-1:0]          : '0;

	// ---------------------------------------------------------------
	// Filter: y = floor((b*x_prev + a*y_prev) / 2^16), b = 2^16 - a
	// ---------------------------------------------------------------
	logic [COEF_W:0]        coef_b;
	logic signed [PW-1:0]   b_x, a_x, xp_x, yp_x;
	logic signed [PW-1:0]   pb_s2, pa_s2;

	assign coef_b = {1'b1, {COEF_W{1'b0}}} - {1'b0, coef_a_q};
	assign b_x    = {{(PW - COEF_W - 1){1'b0}}, coef_b};
	assign a_x    = {{(PW - COEF_W){1'b0}}, coef_a_q};
	assign xp_x   = {{(PW - S){x_prev[S-1]}}, x_prev};
	assign yp_x   = {{(PW - S){y_prev[S-1]}}, y_prev};

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			pb_s2 <= b_x * xp_x;
			pa_s2 <= a_x * yp_x;
		end
	end

	logic signed [PW-1:0] t_sum;
	logic [S-1:0]         y_new;
	logic [SUM_W-1:0]     sum_new;
	logic                 sum_neg;
	logic [SUM_W-1:0]     sum_mag;

	assign t_sum   = pb_s2 + pa_s2;
	assign y_new   = t_sum[COEF_SHIFT + S - 1 -: S];   // arithmetic floor
	assign sum_new = sum_prev + {{(SUM_W - S){y_new[S-1]}}, y_new};
	assign sum_neg = sum_new[SUM_W-1];
	assign sum_mag = sum_neg ? (~sum_new + SUM_W'(1)) : sum_new;

	// closing beat clears the sum; the divider keeps its own copy
	assign wr_data = {in_q[axis_q], y_new, emit_q ? {SUM_W{1'b0}} : sum_new};

	// ---------------------------------------------------------------
	// Restoring divider, one quotient bit per cycle, truncates to zero
	// ---------------------------------------------------------------
	logic [SUM_W-1:0] dq_q;
	logic [CNT_W-1:0] rem_q;
	logic             neg_q;
	logic [CNT_W:0]   rem_sh, rem_sub;
	logic             q_bit;
	logic [SUM_W-1:0] q_fin, q_clip;
	logic [S-1:0]     q_res;

	assign rem_sh  = {rem_q, dq_q[SUM_W-1]};
	assign rem_sub = rem_sh - {1'b0, dec_eff};
	assign q_bit   = (rem_sh >= {1'b0, dec_eff});
	assign q_fin   = {dq_q[SUM_W-2:0], q_bit};

	always_comb begin
		if (neg_q)
			q_clip = (q_fin > NEG_LIM) ? NEG_LIM : q_fin;
		else
			q_clip = (q_fin > POS_LIM) ? POS_LIM : q_fin;
		q_res = neg_q ? (~q_clip[S-1:0] + S'(1)) : q_clip[S-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (div_load) begin
			step_q <= '0;
		end else if (div_step) begin
			step_q <= step_q + STP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (div_load) begin
			dq_q  <= sum_mag;
			neg_q <= sum_neg;
			rem_q <= '0;
		end else if (div_step) begin
			dq_q  <= q_fin;
			rem_q <= q_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
		end
	end

	// per-axis quotients, then handed to the output register
	logic [S-1:0] res_q [AXES];
	logic [S-1:0] out_q [AXES];
	logic         out_valid_q;

	always_ff @(posedge clk) begin
		if (div_step && step_q == STP_LAST)
			res_q[axis_q] <= q_res;
		if (res_load)
			out_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	assign out_valid     = out_valid_q;
	assign mean_force_x  = out_q[0];
	assign mean_force_y  = out_q[1];
	assign mean_force_z  = out_q[2];
	assign mean_torque_x = out_q[3];
	assign mean_torque_y = out_q[4];
	assign mean_torque_z = out_q[5];

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q >= CNT_W'(1)) && (cnt_q <= CNT_W'(MAX_DECIMATION)))
		else $error("window position out of range");

	a_div_only_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> emit_q)
		else $error("divider running on a non-closing beat");

	a_accept_starts_axis0: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_READ) && (axis_q == '0))
		else $error("accepted beat did not start at the first axis");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result raised outside the final state");
`endif

endmodule

FILE: bench/tb_six_axis_iir_lowpass_decimator_core.sv
// Self-checking bench for six_axis_iir_lowpass_decimator_core: random and directed
// six-axis samples, an in-bench filter/mean predictor, APB register writes between phases.
// Depends on sixiir_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_six_axis_iir_lowpass_decimator_core;
	import sixiir_pkg::*;

	localparam int SAMPLE_W     = 16;
	localparam int MAX_DEC      = 256;
	localparam int SETTLE       = 200;        // covers the worst (window-closing) beat
	localparam int LIMIT_CYCLES = 2_000_000;
	localparam int SHOW_MAX     = 10;

	// one beat worth of axes; index 0 = force_x ... 5 = torque_z
	typedef logic [AXES-1:0][SAMPLE_W-1:0] sample_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] force_x = '0, force_y = '0, force_z = '0;
	logic signed [SAMPLE_W-1:0] torque_x = '0, torque_y = '0, torque_z = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] mean_force_x, mean_force_y, mean_force_z;
	logic signed [SAMPLE_W-1:0] mean_torque_x, mean_torque_y, mean_torque_z;
	logic                       psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [APB_AW-1:0]          paddr = '0;
	logic [APB_DW-1:0]          pwdata = '0;
	logic [APB_DW-1:0]          prdata;
	logic                       pready;

	six_axis_iir_lowpass_decimator_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.force_x      (force_x),
		.force_y      (force_y),
		.force_z      (force_z),
		.torque_x     (torque_x),
		.torque_y     (torque_y),
		.torque_z     (torque_z),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mean_force_x (mean_force_x),
		.mean_force_y (mean_force_y),
		.mean_force_z (mean_force_z),
		.mean_torque_x(mean_torque_x),
		.mean_torque_y(mean_torque_y),
		.mean_torque_z(mean_torque_z),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Shared bench state
	// ------------------------------------------------------------------
	sample_t sample_q [$];   // samples waiting for the driver
	sample_t mean_q [$];     // predicted window means, oldest first
	int      send_idle_pct  = 0;
	int      recv_stall_pct = 0;
	int      fail_count     = 0;
	int      cycle_count    = 0;

	// predictor copy of the registers and per-axis filter state
	int     cfg_coef  = 0;
	int     cfg_decim = 1;
	longint last_sample   [AXES] = '{default: 0};
	longint last_filtered [AXES] = '{default: 0};
	longint window_sum    [AXES] = '{default: 0};
	int     window_pos = 1;

	string axis_name [AXES] = '{"force_x", "force_y", "force_z",
		"torque_x", "torque_y", "torque_z"};

	task automatic flag_mismatch(input string what, input longint exp_v, input longint act_v);
		fail_count++;
		if (fail_count <= SHOW_MAX)
			$display("mismatch %s: expected %0d, got %0d", what, exp_v, act_v);
	endtask

	// One accepted beat through the low-pass and the window mean.
	// Filter is one sample late: y uses the previous raw sample, then the
	// new sample is stored. Window closes once the position reaches the
	// (clamped) decimation, which also covers a decimation lowered mid-window.
	task automatic filter_and_average(input sample_t s);
		longint  acc, quot;
		int      span;
		sample_t mean;
		span = (cfg_decim == 0) ? 1 : ((cfg_decim > MAX_DEC) ? MAX_DEC : cfg_decim);
		for (int i = 0; i < AXES; i++) begin
			acc = longint'(65536 - cfg_coef) * last_sample[i]
				+ longint'(cfg_coef) * last_filtered[i];
			last_filtered[i] = acc >>> COEF_SHIFT;   // floor
			last_sample[i]   = longint'($signed(s[i]));
			window_sum[i]   += last_filtered[i];
		end
		if (window_pos < span) begin
			window_pos++;
		end else begin
			for (int i = 0; i < AXES; i++) begin
				quot = window_sum[i] / longint'(span);   // truncates toward zero
				if (quot > 32767)
					quot = 32767;
				else if (quot < -32768)
					quot = -32768;
				mean[i]       = quot[SAMPLE_W-1:0];
				window_sum[i] = 0;
			end
			window_pos = 1;
			mean_q.push_back(mean);
		end
	endtask

	// ------------------------------------------------------------------
	// Sample driver: presents the next queued sample when the slot is free,
	// idling at random. A stalled beat keeps its payload.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : drive_samples
		sample_t nxt;
		if (arst_n) begin
			if (in_valid && !in_stall)
				filter_and_average({torque_z, torque_y, torque_x, force_z, force_y, force_x});
			if (!in_valid || !in_stall) begin
				if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = sample_q.pop_front();
					in_valid <= 1'b1;
					force_x  <= nxt[0];
					force_y  <= nxt[1];
					force_z  <= nxt[2];
					torque_x <= nxt[3];
					torque_y <= nxt[4];
					torque_z <= nxt[5];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver back-pressure, independent each cycle
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	// ------------------------------------------------------------------
	// Mean monitor: every accepted beat against the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_means
		sample_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {mean_torque_z, mean_torque_y, mean_torque_x,
				mean_force_z, mean_force_y, mean_force_x};
			if (mean_q.size() == 0) begin
				flag_mismatch("unexpected mean beat, force_x", 0, $signed(got[0]));
			end else begin
				want = mean_q.pop_front();
				for (int i = 0; i < AXES; i++)
					if (got[i] !== want[i])
						flag_mismatch({"mean_", axis_name[i]},
							$signed(want[i]), $signed(got[i]));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
		input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// write a register, mirror it into the predictor, then read it back
	task automatic write_reg(input logic sel, input int value);
		logic [APB_DW-1:0] rd, want;
		logic [APB_AW-1:0] addr;
		addr = {sel, 2'b00};
		want = (sel == REG_COEF_A) ? APB_DW'(value[COEF_W-1:0])
			: APB_DW'(value[DEC_REG_W-1:0]);
		apb_access(1'b1, addr, APB_DW'(value), rd);
		if (sel == REG_COEF_A)
			cfg_coef = int'(want);
		else
			cfg_decim = int'(want);
		apb_access(1'b0, addr, '0, rd);
		if (rd !== want)
			flag_mismatch(sel == REG_COEF_A ? "coef_a readback" : "decimation readback",
				want, rd);
	endtask

	// hold off until every queued sample is taken and every mean has come out,
	// then let the last beat's processing finish
	task automatic wait_drained();
		do @(negedge clk);
		while (sample_q.size() != 0 || in_valid || mean_q.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic sample_t uniform(input logic [SAMPLE_W-1:0] v);
		sample_t s;
		for (int i = 0; i < AXES; i++)
			s[i] = v;
		return s;
	endfunction

	// mostly full-range random, with extremes mixed in per axis
	function automatic sample_t random_sample();
		sample_t s;
		for (int i = 0; i < AXES; i++)
			case ($urandom_range(7))
				0: s[i] = 16'h8000;
				1: s[i] = 16'h7FFF;
				2: s[i] = ($urandom_range(1) != 0) ? 16'h0000 : 16'hFFFF;
				default: s[i] = SAMPLE_W'($urandom);
			endcase
		return s;
	endfunction

	// one random phase: registers, idling mix, and a mid-phase drain pause
	task automatic run_phase(input int coef, input int decim, input int send_pct,
		input int recv_pct, input int count);
		write_reg(REG_COEF_A, coef);
		write_reg(REG_DECIMATION, decim);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		repeat (count / 2) sample_q.push_back(random_sample());
		wait_drained();
		repeat (count - count / 2) sample_q.push_back(random_sample());
		wait_drained();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// coefficient zero: each filtered value is just the previous sample
		write_reg(REG_COEF_A, 0);
		write_reg(REG_DECIMATION, 1);
		sample_q.push_back(uniform(16'h8000));
		sample_q.push_back(uniform(16'h7FFF));
		sample_q.push_back(uniform(16'h0000));
		sample_q.push_back(uniform(16'hFFFF));
		sample_q.push_back(sample_t'({3{16'h7FFF, 16'h8000}}));
		wait_drained();

		// full feedback; decimation zero acts as one
		write_reg(REG_COEF_A, 65535);
		write_reg(REG_DECIMATION, 0);
		sample_q.push_back(sample_t'({3{16'h8000, 16'h7FFF}}));
		sample_q.push_back(uniform(16'h7FFF));
		sample_q.push_back(uniform(16'h8000));
		wait_drained();

		// long window cut short by a lower decimation: mean saturates high
		write_reg(REG_COEF_A, 0);
		write_reg(REG_DECIMATION, MAX_DEC);
		repeat (10) sample_q.push_back(uniform(16'h7FFF));
		wait_drained();
		write_reg(REG_DECIMATION, 1);
		sample_q.push_back(uniform(16'h7FFF));
		wait_drained();

		// same thing on the negative side
		write_reg(REG_DECIMATION, MAX_DEC);
		repeat (6) sample_q.push_back(uniform(16'h8000));
		wait_drained();
		write_reg(REG_DECIMATION, 2);
		sample_q.push_back(uniform(16'h8000));
		wait_drained();

		// random phases; decimation changes land mid-window between phases
		run_phase($urandom_range(65535), 1, 0, 0, 250);
		run_phase(65535, 5, 74, 0, 200);
		run_phase($urandom_range(65535), 3, 0, 74, 200);
		run_phase(0, 511, 33, 33, 300);   // above the max, clamps to 256
		run_phase($urandom_range(65535), 16, 0, 0, 250);
		run_phase($urandom_range(65535), 0, 74, 0, 150);
		run_phase(1, 2, 0, 74, 150);
		run_phase($urandom_range(65535), $urandom_range(12, 1), 33, 33, 150);

		if (fail_count == 0 && mean_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
